// File: sv/bba_pkg.sv
package bba_pkg;

	// bitmap geometry
	localparam int MAP_BITS  = 8192;
	localparam int WORD_BITS = 32;
	localparam int WORDS     = MAP_BITS / WORD_BITS;
	localparam int WIDX_W    = $clog2(WORDS);
	localparam int WBIT_W    = $clog2(WORD_BITS);

	// field widths
	localparam int NUM_W  = 14;
	localparam int STAT_W = 2;

	// request modes
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;

	typedef struct packed {
		logic             mode;
		logic [NUM_W-1:0] entry_number;
	} req_t;

	typedef struct packed {
		logic [NUM_W-1:0]  allocated_number;
		logic [STAT_W-1:0] status;
		logic [NUM_W-1:0]  free_count;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic take_req;   // capture request
		logic ptr_clr;    // restart word scan
		logic ptr_inc;    // advance word scan
		logic sel_free;   // read the word that holds the freed entry
		logic alloc_chk;  // evaluate scanned word
		logic free_chk;   // evaluate freed entry
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic mode;       // mode of the captured request
		logic found;      // scanned word holds a free entry
		logic last;       // scanned word is the last in range
	} stat_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LEAD = 4'b0010,
		S_SCAN = 4'b0100,
		S_FCHK = 4'b1000
	} state_t;

endpackage

// File: sv/bba_ctrl.sv
module bba_ctrl
	import bba_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output logic  busy,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.take_req = 1'b1;
					cmd.ptr_clr  = 1'b1;
					state_nxt    = S_LEAD;
				end
			end
			S_LEAD: begin
				// first read is in flight
				cmd.sel_free = (stat.mode == MODE_FREE);
				cmd.ptr_inc  = 1'b1;
				state_nxt    = (stat.mode == MODE_FREE) ? S_FCHK : S_SCAN;
			end
			S_SCAN: begin
				// check previous word while reading the next one
				cmd.alloc_chk = 1'b1;
				cmd.ptr_inc   = 1'b1;
				if (stat.found || stat.last) begin
					state_nxt = S_IDLE;
				end
			end
			S_FCHK: begin
				cmd.free_chk = 1'b1;
				state_nxt    = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// File: sv/bba_dp.sv
module bba_dp
	import bba_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  req_t             req,
	input  logic             cfg_we,
	input  logic [NUM_W-1:0] cfg_wdata,
	input  cmd_t             cmd,
	output stat_t            stat,
	output logic             done,
	output rsp_t             result
);

	// bitmap storage, one word per row, rows marked valid once written
	logic [WORD_BITS-1:0] mem [WORDS];
	logic [WORD_BITS-1:0] rd_q;
	logic [WORDS-1:0]     vld_q;

	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  cnt_q;
	req_t              req_q;
	logic [WIDX_W-1:0] ptr_q;
	logic [WIDX_W-1:0] chk_s1;
	logic              done_q;
	rsp_t              res_q;

	logic [NUM_W-1:0]     neff;
	logic [NUM_W-1:0]     fnum_m1;
	logic [WIDX_W-1:0]    raddr;
	logic [WORD_BITS-1:0] word;
	logic [NUM_W-1:0]     base;
	logic [NUM_W-1:0]     rem;
	logic [WORD_BITS-1:0] lim;
	logic [WORD_BITS-1:0] cand;
	logic [WBIT_W-1:0]    bidx;
	logic [WIDX_W:0]      nxt_w;
	logic [NUM_W-1:0]     end_bits;
	logic                 found;
	logic                 last;
	logic                 fbad;
	logic                 we;
	logic [WORD_BITS-1:0] wdata;
	logic [NUM_W-1:0]     cnt_nxt;
	logic [NUM_W-1:0]     free_nxt;

	// entry count clamped to map size
	assign neff    = (num_q > NUM_W'(MAP_BITS)) ? NUM_W'(MAP_BITS) : num_q;
	assign fnum_m1 = req_q.entry_number - 1'b1;
	assign raddr   = cmd.sel_free ? fnum_m1[WBIT_W +: WIDX_W] : ptr_q;

	// word under check; unwritten rows read as all free
	assign word = vld_q[chk_s1] ? rd_q : '0;

	// entries of this word that lie inside the configured range
	assign base = NUM_W'({chk_s1, WBIT_W'(0)});
	assign rem  = neff - base;
	assign lim  = (rem >= NUM_W'(WORD_BITS)) ? '1
	            : ((WORD_BITS'(1) << rem[WBIT_W-1:0]) - 1'b1);
	assign cand = ~word & lim;

	assign found    = |cand;
	assign nxt_w    = {1'b0, chk_s1} + 1'b1;
	assign end_bits = NUM_W'({nxt_w, WBIT_W'(0)});
	assign last     = (end_bits >= neff);

	// lowest free bit
	always_comb begin
		bidx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (cand[i]) begin
				bidx = WBIT_W'(i);
			end
		end
	end

	// freed entry must be in range and currently used
	assign fbad = (req_q.entry_number == '0) || (req_q.entry_number > neff)
	            || !word[fnum_m1[WBIT_W-1:0]];

	// row update and used count
	always_comb begin
		we      = 1'b0;
		wdata   = word;
		cnt_nxt = cnt_q;
		if (cmd.alloc_chk && found) begin
			we      = 1'b1;
			wdata   = word | (WORD_BITS'(1) << bidx);
			cnt_nxt = cnt_q + 1'b1;
		end else if (cmd.free_chk && !fbad) begin
			we      = 1'b1;
			wdata   = word & ~(WORD_BITS'(1) << fnum_m1[WBIT_W-1:0]);
			cnt_nxt = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
		end
	end

	assign free_nxt = (cnt_nxt >= neff) ? '0 : neff - cnt_nxt;

	// bitmap memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[chk_s1] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// row valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[chk_s1] <= 1'b1;
		end
	end

	// configuration, count, scan pointer and done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= NUM_W'(MAP_BITS);
			cnt_q  <= '0;
			ptr_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				num_q <= cfg_wdata;
			end
			cnt_q <= cnt_nxt;
			if (cmd.ptr_clr) begin
				ptr_q <= '0;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + 1'b1;
			end
			done_q <= (cmd.alloc_chk && (found || last)) || cmd.free_chk;
		end
	end

	// request capture, read address tracking and result
	always_ff @(posedge clk) begin
		if (cmd.take_req) begin
			req_q <= req;
		end
		chk_s1 <= raddr;
		if (cmd.alloc_chk) begin
			res_q.allocated_number <= found ? base + NUM_W'(bidx) + 1'b1 : '0;
			res_q.status           <= found ? STAT_OK : STAT_FULL;
			res_q.free_count       <= free_nxt;
		end else if (cmd.free_chk) begin
			res_q.allocated_number <= '0;
			res_q.status           <= fbad ? STAT_BAD : STAT_OK;
			res_q.free_count       <= free_nxt;
		end
	end

	assign stat.mode  = req_q.mode;
	assign stat.found = found;
	assign stat.last  = last;
	assign done       = done_q;
	assign result     = res_q;

endmodule

// File: sv/block_bitmap_allocator.sv
// First-fit bitmap allocator over 8192 entries, all free after reset. A
// transaction is taken when start is high and busy is low. An allocation
// reads the bitmap one 32-bit word per cycle from the bottom up to the first
// free entry or the last word in range (1 to 256 words); a free holds busy
// through a lead and a check state. The result is shown on result for the
// single cycle in which done is high, the first cycle after busy falls; it
// cannot be held off, and a new start may be given in that same cycle. The
// user must write number_of_entries through cfg_we/cfg_wdata only while
// idle; the block does not enforce this. Values above 8192 act as 8192.
module block_bitmap_allocator
	import bba_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  req_t             req,
	output logic             busy,
	input  logic             cfg_we,
	input  logic [NUM_W-1:0] cfg_wdata,
	output logic             done,
	output rsp_t             result
);

	cmd_t  cmd;
	stat_t stat;

	bba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	bba_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.done      (done),
		.result    (result)
	);

endmodule

// File: dv/bba_checker.sv
module bba_checker
	import bba_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  req_t             req,
	input  logic             busy,
	input  logic             cfg_we,
	input  logic [NUM_W-1:0] cfg_wdata,
	input  logic             done,
	input  rsp_t             result,
	output int               fail_count,
	output int               outstanding
);

	localparam int MIDX_W = $clog2(MAP_BITS);

	// shadow copy of the allocator state
	bit [MAP_BITS-1:0] used_map;
	int unsigned       used_total;
	logic [NUM_W-1:0]  entry_limit;
	rsp_t              answer_q[$];
	int                mismatches;

	// apply one request to the shadow bitmap and return the answer it earns
	function automatic rsp_t serve_request(input req_t r);
		rsp_t        rsp;
		int unsigned limit;
		limit = (entry_limit > MAP_BITS) ? MAP_BITS : entry_limit;
		rsp = '0;
		if (r.mode == MODE_ALLOC) begin
			rsp.status = STAT_FULL;
			for (int unsigned i = 0; i < limit; i++) begin
				if (!used_map[MIDX_W'(i)]) begin
					used_map[MIDX_W'(i)] = 1'b1;
					used_total++;
					rsp.allocated_number = NUM_W'(i + 1);
					rsp.status = STAT_OK;
					break;
				end
			end
		end else if (r.entry_number == 0 || r.entry_number > limit ||
				!used_map[MIDX_W'(r.entry_number - 1'b1)]) begin
			rsp.status = STAT_BAD;
		end else begin
			used_map[MIDX_W'(r.entry_number - 1'b1)] = 1'b0;
			if (used_total > 0)
				used_total--;
			rsp.status = STAT_OK;
		end
		// entries above a lowered limit stay counted, so clamp at zero
		rsp.free_count = (used_total >= limit) ? '0 : NUM_W'(limit - used_total);
		return rsp;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			used_map = '0;
			used_total = 0;
			entry_limit = NUM_W'(MAP_BITS);
			answer_q.delete();
			outstanding <= 0;
		end else begin
			// result strobe: compare against the oldest pending answer
			if (done) begin
				if (answer_q.size() == 0) begin
					$display("%0t: result expected none pending, got %p", $time, result);
					mismatches++;
				end else begin
					want = answer_q.pop_front();
					if (result.allocated_number !== want.allocated_number) begin
						$display("%0t: allocated_number expected %0d, got %0d",
							$time, want.allocated_number, result.allocated_number);
						mismatches++;
					end
					if (result.status !== want.status) begin
						$display("%0t: status expected %0d, got %0d",
							$time, want.status, result.status);
						mismatches++;
					end
					if (result.free_count !== want.free_count) begin
						$display("%0t: free_count expected %0d, got %0d",
							$time, want.free_count, result.free_count);
						mismatches++;
					end
				end
			end
			if (cfg_we)
				entry_limit = cfg_wdata;
			// accepted transaction
			if (start && !busy)
				answer_q.push_back(serve_request(req));
			outstanding <= answer_q.size();
		end
		fail_count <= mismatches;
	end

endmodule

// File: dv/tb_top.sv
module tb_top;
	import bba_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 1_000_000;
	localparam int unsigned PHASES       = 10;
	localparam int unsigned PHASE_ITEMS  = 65;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	req_t             req       = '0;
	logic             cfg_we    = 1'b0;
	logic [NUM_W-1:0] cfg_wdata = '0;
	logic             busy;
	logic             done;
	rsp_t             result;
	int               fail_count;
	int               outstanding;

	int unsigned cycle_cnt;
	int unsigned cur_entries = MAP_BITS;  // effective entry count, steers free numbers
	bit          no_gaps;

	always #2 clk = ~clk;

	block_bitmap_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

	bba_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.req         (req),
		.busy        (busy),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.result      (result),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// one transaction, then an optional gap; start stays high when no gap
	task automatic issue(input logic m, input logic [NUM_W-1:0] num);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		start <= 1'b1;
		req <= req_t'{mode: m, entry_number: num};
		do @(posedge clk); while (busy);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// wait for the block to go idle with every answer delivered
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (busy || outstanding != 0);
	endtask

	task automatic set_entries(input logic [NUM_W-1:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_entries = (v > MAP_BITS) ? MAP_BITS : v;
	endtask

	// mostly low numbers (first fit keeps them dense), some out of range, some noise
	function automatic logic [NUM_W-1:0] pick_free_number();
		int unsigned hi;
		int unsigned sel;
		hi = (cur_entries < 48) ? cur_entries : 48;
		if (hi == 0)
			hi = 1;
		sel = $urandom_range(0, 9);
		if (sel < 7)
			return NUM_W'($urandom_range(1, hi));
		else if (sel < 9)
			return NUM_W'($urandom_range(0, cur_entries + 2));
		return NUM_W'($urandom());
	endfunction

	function automatic logic [NUM_W-1:0] phase_entries(input int unsigned p);
		case (p % 10)
			0: return NUM_W'(MAP_BITS);
			1: return NUM_W'($urandom_range(1, 16));
			2: return NUM_W'(32);
			3: return '1;
			4: return '0;
			5: return NUM_W'($urandom_range(33, 300));
			6: return NUM_W'(1);
			7: return NUM_W'($urandom_range(MAP_BITS + 1, 16382));
			8: return NUM_W'(33);
			default: return NUM_W'($urandom_range(2, 64));
		endcase
	endfunction

	// stimulus and verdict
	initial begin
		int unsigned drain_cnt;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: basic alloc/free, bad numbers, double free
		issue(MODE_ALLOC, '0);
		issue(MODE_ALLOC, '0);
		issue(MODE_FREE, '0);
		issue(MODE_FREE, NUM_W'(MAP_BITS));
		issue(MODE_FREE, '1);
		issue(MODE_FREE, NUM_W'(1));
		issue(MODE_FREE, NUM_W'(1));
		issue(MODE_ALLOC, '0);
		// zero entries: nothing allocatable, every free is bad
		set_entries('0);
		issue(MODE_ALLOC, '0);
		issue(MODE_FREE, NUM_W'(1));
		// limit lowered below used entries: free count clamps at zero
		set_entries(NUM_W'(1));
		issue(MODE_ALLOC, '0);
		issue(MODE_FREE, NUM_W'(2));
		issue(MODE_FREE, NUM_W'(1));
		issue(MODE_ALLOC, '0);
		// limit above the map size acts as the map size
		set_entries('1);
		issue(MODE_ALLOC, '0);
		issue(MODE_FREE, NUM_W'(3));
		issue(MODE_FREE, NUM_W'(MAP_BITS + 1));
		issue(MODE_ALLOC, '1);

		// random phases, each under its own entry count
		for (int unsigned p = 0; p < PHASES; p++) begin
			set_entries(phase_entries(p));
			no_gaps = (p % 3 == 1);
			for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 99) < 55)
					issue(MODE_ALLOC, NUM_W'($urandom()));
				else
					issue(MODE_FREE, pick_free_number());
			end
		end

		// drain, bounded
		start <= 1'b0;
		drain_cnt = 0;
		do begin
			@(posedge clk);
			drain_cnt++;
		end while ((busy || outstanding != 0) && drain_cnt < 5000);
		repeat (300) @(posedge clk);

		if (fail_count == 0 && outstanding == 0)
			$display("block_bitmap_allocator verification clean");
		else
			$display("block_bitmap_allocator verification failed");
		$finish;
	end

	// watchdog
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("block_bitmap_allocator verification failed");
		$finish;
	end

endmodule

// File: sim.f
sv/bba_pkg.sv
sv/bba_ctrl.sv
sv/bba_dp.sv
sv/block_bitmap_allocator.sv
dv/bba_checker.sv
dv/tb_top.sv
